>>> hw/rtl/bmhq_pkg.sv
// Shared types for the binary min-heap queue: cell operations and chain control.
`timescale 1ns / 1ps

package bmhq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SIFT,
        OP_FETCH
    } cell_op_e;

    typedef struct packed {
        logic     vld;
        cell_op_e op;
    } tok_ctl_t;

    typedef struct packed {
        logic done;
        logic fetch_vld;
    } cell_resp_t;

    localparam int KEY_PORT_W = 32;
    localparam int COUNT_W    = 11;

endpackage

>>> hw/rtl/bmhq_cell.sv
// One heap level: pair memory for the level, a registered compare stage and links to neighbours.
`timescale 1ns / 1ps

module bmhq_cell import bmhq_pkg::*; #(
    parameter int LVL = 1,
    parameter int PW  = 11,
    parameter int LW  = 4,
    parameter int KW  = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tok_ctl_t      in_ctl,
    input  logic [KW-1:0] in_key,
    input  logic [PW-1:0] in_pos,
    input  logic [LW-1:0] in_depth,
    input  logic [PW-1:0] in_n,
    output tok_ctl_t      fwd_ctl,
    output logic [KW-1:0] fwd_key,
    output logic [PW-1:0] fwd_pos,
    output logic [LW-1:0] fwd_depth,
    output logic [PW-1:0] fwd_n,
    input  logic          up_in_wr,
    input  logic [PW-1:0] up_in_pos,
    input  logic [KW-1:0] up_in_key,
    output logic          up_wr,
    output logic [PW-1:0] up_pos,
    output logic [KW-1:0] up_key,
    output cell_resp_t    resp,
    output logic [KW-1:0] resp_key
);

    localparam int RW   = (LVL > 1) ? LVL - 1 : 1;
    localparam int ROWS = 1 << (LVL - 1);

    logic [KW-1:0] mem_lo [ROWS];
    logic [KW-1:0] mem_hi [ROWS];

    logic [KW-1:0] rd_lo_reg;
    logic [KW-1:0] rd_hi_reg;

    tok_ctl_t      s1_ctl_reg;
    logic [KW-1:0] s1_key_reg;
    logic [PW-1:0] s1_pos_reg;
    logic [LW-1:0] s1_depth_reg;
    logic [PW-1:0] s1_n_reg;
    logic [PW-1:0] s1_anc_reg;

    logic [LW-1:0] sh;
    logic [PW-1:0] anc;
    logic [RW-1:0] rd_row;

    logic [KW-1:0] cur;
    logic          at_lvl;
    logic [PW:0]   lc;
    logic [PW:0]   rc;
    logic [PW:0]   n_ext;
    logic          rc_ok;
    logic          take_l;
    logic          take_r;
    logic          moved;
    logic [KW-1:0] bv;
    logic [KW-1:0] cv;
    logic [PW:0]   c_full;
    logic [PW-1:0] c;
    logic          grand_ok;

    logic          own_wr;
    logic [RW-1:0] own_row;
    logic          own_slot;
    logic [KW-1:0] own_key;
    logic          wr_en;
    logic [RW-1:0] wr_row;
    logic          wr_slot;
    logic [KW-1:0] wr_key;

    // row of a position that lies on this level; slot is bit 0
    function automatic logic [RW-1:0] row_of(input logic [PW:0] p);
        row_of = RW'(p[LVL-1:0] >> 1);
    endfunction

    // read address from the arriving transfer
    always_comb begin
        sh  = in_depth - LW'(LVL);
        anc = in_pos >> sh;
        case (in_ctl.op)
            OP_SIFT: rd_row = row_of({in_pos, 1'b0});
            default: rd_row = row_of({1'b0, anc});
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_lo_reg <= mem_lo[rd_row];
        rd_hi_reg <= mem_hi[rd_row];
        if (wr_en && !wr_slot) begin
            mem_lo[wr_row] <= wr_key;
        end
        if (wr_en && wr_slot) begin
            mem_hi[wr_row] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ctl_reg.op <= in_ctl.op;
        s1_key_reg    <= in_key;
        s1_pos_reg    <= in_pos;
        s1_depth_reg  <= in_depth;
        s1_n_reg      <= in_n;
        s1_anc_reg    <= anc;
        if (!aresetn) begin
            s1_ctl_reg.vld <= 1'b0;
        end else begin
            s1_ctl_reg.vld <= in_ctl.vld;
        end
    end

    // sift-down choice among the two children of the hole in the level above
    always_comb begin
        cur      = s1_anc_reg[0] ? rd_hi_reg : rd_lo_reg;
        at_lvl   = (s1_depth_reg == LW'(LVL));
        lc       = {s1_pos_reg, 1'b0};
        rc       = {s1_pos_reg, 1'b1};
        n_ext    = {1'b0, s1_n_reg};
        rc_ok    = (rc <= n_ext);
        take_l   = (rd_lo_reg < s1_key_reg);
        bv       = take_l ? rd_lo_reg : s1_key_reg;
        take_r   = rc_ok && (rd_hi_reg < bv);
        moved    = take_l || take_r;
        c_full   = take_r ? rc : lc;
        c        = c_full[PW-1:0];
        cv       = take_r ? rd_hi_reg : rd_lo_reg;
        grand_ok = ({c, 1'b0} <= n_ext);
    end

    always_comb begin
        fwd_ctl     = s1_ctl_reg;
        fwd_ctl.vld = 1'b0;
        fwd_key     = s1_key_reg;
        fwd_pos     = s1_pos_reg;
        fwd_depth   = s1_depth_reg;
        fwd_n       = s1_n_reg;
        up_wr       = 1'b0;
        up_pos      = s1_pos_reg;
        up_key      = s1_key_reg;
        resp        = '0;
        resp_key    = '0;
        own_wr      = 1'b0;
        own_row     = row_of({1'b0, s1_anc_reg});
        own_slot    = s1_anc_reg[0];
        own_key     = s1_key_reg;
        if (s1_ctl_reg.vld) begin
            case (s1_ctl_reg.op)
                OP_INSERT: begin
                    if (at_lvl) begin
                        own_wr    = 1'b1;
                        resp.done = 1'b1;
                    end else begin
                        fwd_ctl.vld = 1'b1;
                        if (s1_key_reg < cur) begin
                            own_wr  = 1'b1;
                            fwd_key = cur;
                        end
                    end
                end
                OP_FETCH: begin
                    if (at_lvl) begin
                        resp.fetch_vld = 1'b1;
                        resp_key       = cur;
                    end else begin
                        fwd_ctl.vld = 1'b1;
                    end
                end
                OP_SIFT: begin
                    up_wr = 1'b1;
                    if (!moved) begin
                        resp.done = 1'b1;
                    end else begin
                        up_key = cv;
                        if (grand_ok) begin
                            fwd_ctl.vld = 1'b1;
                            fwd_pos     = c;
                        end else begin
                            own_wr    = 1'b1;
                            own_row   = row_of({1'b0, c});
                            own_slot  = c[0];
                            resp.done = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // hole fill from the level below takes the write port
    always_comb begin
        wr_en = own_wr || up_in_wr;
        if (up_in_wr) begin
            wr_row  = row_of({1'b0, up_in_pos});
            wr_slot = up_in_pos[0];
            wr_key  = up_in_key;
        end else begin
            wr_row  = own_row;
            wr_slot = own_slot;
            wr_key  = own_key;
        end
    end

endmodule

>>> hw/rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue: root register, sequencer and a chain of level cells.
`timescale 1ns / 1ps

// Holds up to CAPACITY unsigned keys of KEY_WIDTH bits. Each input transfer is an insert
// (s_tuser 0, key in s_tdata) or an extract-minimum (s_tuser 1); each gives one result
// transfer with the extracted key, a status (0 ok, 1 extract on empty, 2 insert on full),
// the minimum held afterwards and the key count. The root sits in a register; every deeper
// heap level is one cell with its own memory, and an operation walks the chain one level per
// cycle. An extract walks the chain once to fetch the last key and, if more than one key
// remains, once more to sift it down from the root. Inserts into an empty queue or onto a
// full one and extracts of the single key or on an empty queue do not enter the chain. One
// item is worked on at a time; the next is taken once the result has moved to the output
// register. No clearing pass is needed after reset.
module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key_in[31:0]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // key_out[31:0], min_key[63:32], min_valid[64], count[75:65]
    output logic [1:0]  m_tuser    // status
);

    localparam int PW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = PW;
    localparam int LW     = $clog2(LEVELS);
    localparam int KW     = KEY_WIDTH;

    localparam logic       FUNC_INSERT = 1'b0;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_WAIT,
        S_RESULT
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] root_reg, root_next;
    logic [KW-1:0] res_key_reg, res_key_next;
    logic [1:0]    res_status_reg, res_status_next;

    tok_ctl_t      tok_ctl_reg, tok_ctl_next;
    logic [KW-1:0] tok_key_reg, tok_key_next;
    logic [PW-1:0] tok_pos_reg, tok_pos_next;
    logic [LW-1:0] tok_depth_reg, tok_depth_next;
    logic [PW-1:0] tok_n_reg, tok_n_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [KEY_PORT_W-1:0] out_key_reg, out_key_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [KEY_PORT_W-1:0] out_min_reg, out_min_next;
    logic                  out_minv_reg, out_minv_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    tok_ctl_t      ch_ctl   [1:LEVELS];
    logic [KW-1:0] ch_key   [1:LEVELS];
    logic [PW-1:0] ch_pos   [1:LEVELS];
    logic [LW-1:0] ch_depth [1:LEVELS];
    logic [PW-1:0] ch_n     [1:LEVELS];

    logic          up_wr  [1:LEVELS];
    logic [PW-1:0] up_pos [1:LEVELS];
    logic [KW-1:0] up_key [1:LEVELS];

    cell_resp_t    resp     [1:LEVELS-1];
    logic [KW-1:0] resp_key [1:LEVELS-1];

    logic          done_any;
    logic          fetch_vld_any;
    logic [KW-1:0] fetch_key_any;

    logic [KW-1:0] key_in;
    logic [PW-1:0] cnt_inc;
    logic [PW-1:0] cnt_dec;

    function automatic logic [LW-1:0] depth_of(input logic [PW-1:0] v);
        logic [LW-1:0] d;
        d = '0;
        for (int i = 0; i < PW; i++) begin
            if (v[i]) begin
                d = LW'(i);
            end
        end
        return d;
    endfunction

    assign key_in  = KW'({{KW{1'b0}}, s_tdata});
    assign cnt_inc = cnt_reg + PW'(1);
    assign cnt_dec = cnt_reg - PW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_count_reg, out_minv_reg, out_min_reg, out_key_reg};
    assign m_tuser  = out_status_reg;

    // chain of level cells
    assign ch_ctl[1]   = tok_ctl_reg;
    assign ch_key[1]   = tok_key_reg;
    assign ch_pos[1]   = tok_pos_reg;
    assign ch_depth[1] = tok_depth_reg;
    assign ch_n[1]     = tok_n_reg;

    assign up_wr[LEVELS]  = 1'b0;
    assign up_pos[LEVELS] = '0;
    assign up_key[LEVELS] = '0;

    for (genvar k = 1; k < LEVELS; k++) begin : g_cell
        bmhq_cell #(
            .LVL (k),
            .PW  (PW),
            .LW  (LW),
            .KW  (KW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (ch_ctl[k]),
            .in_key    (ch_key[k]),
            .in_pos    (ch_pos[k]),
            .in_depth  (ch_depth[k]),
            .in_n      (ch_n[k]),
            .fwd_ctl   (ch_ctl[k+1]),
            .fwd_key   (ch_key[k+1]),
            .fwd_pos   (ch_pos[k+1]),
            .fwd_depth (ch_depth[k+1]),
            .fwd_n     (ch_n[k+1]),
            .up_in_wr  (up_wr[k+1]),
            .up_in_pos (up_pos[k+1]),
            .up_in_key (up_key[k+1]),
            .up_wr     (up_wr[k]),
            .up_pos    (up_pos[k]),
            .up_key    (up_key[k]),
            .resp      (resp[k]),
            .resp_key  (resp_key[k])
        );
    end

    always_comb begin
        done_any      = 1'b0;
        fetch_vld_any = 1'b0;
        fetch_key_any = '0;
        for (int k = 1; k < LEVELS; k++) begin
            done_any      = done_any | resp[k].done;
            fetch_vld_any = fetch_vld_any | resp[k].fetch_vld;
            fetch_key_any = fetch_key_any | resp_key[k];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        root_next       = root_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        tok_ctl_next     = tok_ctl_reg;
        tok_ctl_next.vld = 1'b0;
        tok_key_next    = tok_key_reg;
        tok_pos_next    = tok_pos_reg;
        tok_depth_next  = tok_depth_reg;
        tok_n_next      = tok_n_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_min_next    = out_min_reg;
        out_minv_next   = out_minv_reg;
        out_count_next  = out_count_reg;

        if (up_wr[1]) begin
            root_next = up_key[1];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_key_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESULT;
                    if (s_tuser == FUNC_INSERT) begin
                        if (cnt_reg == PW'(CAPACITY)) begin
                            res_status_next = ST_FULL;
                        end else if (cnt_reg == '0) begin
                            root_next = key_in;
                            cnt_next  = cnt_inc;
                        end else begin
                            cnt_next         = cnt_inc;
                            tok_ctl_next.vld = 1'b1;
                            tok_ctl_next.op  = OP_INSERT;
                            tok_pos_next     = cnt_inc;
                            tok_depth_next   = depth_of(cnt_inc);
                            tok_n_next       = cnt_inc;
                            if (key_in < root_reg) begin
                                root_next    = key_in;
                                tok_key_next = root_reg;
                            end else begin
                                tok_key_next = key_in;
                            end
                            state_next = S_WAIT;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_key_next = root_reg;
                            cnt_next     = cnt_dec;
                            if (cnt_reg != PW'(1)) begin
                                tok_ctl_next.vld = 1'b1;
                                tok_ctl_next.op  = OP_FETCH;
                                tok_pos_next     = cnt_reg;
                                tok_depth_next   = depth_of(cnt_reg);
                                tok_n_next       = cnt_reg;
                                state_next       = S_FETCH;
                            end
                        end
                    end
                end
            end
            S_FETCH: begin
                if (fetch_vld_any) begin
                    if (cnt_reg == PW'(1)) begin
                        root_next  = fetch_key_any;
                        state_next = S_RESULT;
                    end else begin
                        tok_ctl_next.vld = 1'b1;
                        tok_ctl_next.op  = OP_SIFT;
                        tok_key_next     = fetch_key_any;
                        tok_pos_next     = PW'(1);
                        tok_n_next       = cnt_reg;
                        state_next       = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (done_any) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_key_next    = KEY_PORT_W'({{KEY_PORT_W{1'b0}}, res_key_reg});
                    out_status_next = res_status_reg;
                    out_minv_next   = (cnt_reg != '0);
                    out_min_next    = (cnt_reg != '0)
                                    ? KEY_PORT_W'({{KEY_PORT_W{1'b0}}, root_reg}) : '0;
                    out_count_next  = COUNT_W'({{COUNT_W{1'b0}}, cnt_reg});
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        root_reg       <= root_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        tok_ctl_reg.op <= tok_ctl_next.op;
        tok_key_reg    <= tok_key_next;
        tok_pos_reg    <= tok_pos_next;
        tok_depth_reg  <= tok_depth_next;
        tok_n_reg      <= tok_n_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_min_reg    <= out_min_next;
        out_minv_reg   <= out_minv_next;
        out_count_reg  <= out_count_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            tok_ctl_reg.vld <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            tok_ctl_reg.vld <= tok_ctl_next.vld;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !ch_ctl[LEVELS].vld)
        else $error("transfer ran off the last heap level");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= PW'(CAPACITY))
        else $error("key count above capacity");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done_any |-> state_reg == S_WAIT)
        else $error("cell completion outside a walk");

    a_fetch_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_vld_any |-> state_reg == S_FETCH)
        else $error("last-key fetch returned outside fetch state");
`endif

endmodule
